// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
   `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== hw/rtl/slfe_pkg.sv =====
`default_nettype none

package slfe_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;

   // port field widths
   localparam int FIELD_W     = 16;
   localparam int SEG_W       = 6;
   localparam int ERR_W       = 48;
   localparam int STAT_W      = 2;
   localparam int IN_DATA_W   = ((2 * FIELD_W + 7) / 8) * 8;
   localparam int IN_USER_W   = 1;
   localparam int OUT_DATA_W  = ((2 * SEG_W + ERR_W + 7) / 8) * 8;
   localparam int OUT_PAD_W   = OUT_DATA_W - 2 * SEG_W - ERR_W;
   localparam int OUT_USER_W  = STAT_W;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int IDX_W = $clog2(MAX_POINTS);

   // prefix sum widths
   localparam int PS_W  = COORD_BITS + IDX_W + 1;
   localparam int PXY_W = 2 * COORD_BITS + IDX_W;
   localparam int PSQ_W = 2 * COORD_BITS + IDX_W - 1;
   localparam int RAM_W = 2 * PS_W + PXY_W + 2 * PSQ_W;

   // fit arithmetic
   localparam int OP_W    = 2 * COORD_BITS + 2 * CNT_W + 2;
   localparam int HALF_W  = OP_W / 2;
   localparam int PROD_W  = 2 * HALF_W + 2;
   localparam int ACC_W   = 2 * OP_W;
   localparam int DIV_W   = ACC_W + FRAC_BITS + 1;
   localparam int REM_W   = ACC_W + 2;
   localparam int QCNT_W  = $clog2(ERR_W + 1);
   localparam int NUM_PROD  = 9;
   localparam int STEP_LAST = NUM_PROD * 4 - 1;
   localparam int STEP_W    = $clog2(NUM_PROD * 4);
   localparam int PIDX_W    = STEP_W - 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_VERTICAL = 2'd1,
      ST_ORDER    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      JOB_FIT,
      JOB_ORDER,
      JOB_FULL
   } job_kind_type;

   typedef struct packed {
      job_kind_type     kind;
      logic [IDX_W-1:0] j;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic [PS_W-1:0]  sx;
      logic [PS_W-1:0]  sy;
      logic [PXY_W-1:0] sxy;
      logic [PSQ_W-1:0] sxx;
      logic [PSQ_W-1:0] syy;
   } prefix_type;

   typedef enum logic [3:0] {
      OPD_N, OPD_SX, OPD_SY, OPD_SXY, OPD_SXX, OPD_SYY, OPD_D, OPD_NN, OPD_V
   } operand_type;

   typedef enum logic [2:0] {
      DST_D, DST_N, DST_V, DST_NUM, DST_DEN
   } dest_type;

   typedef struct packed {
      operand_type a;
      operand_type b;
      logic        sub;
      logic        first;
      logic        last;
      dest_type    dest;
   } mac_op_type;

   typedef struct packed {
      logic       valid;
      logic       sub;
      logic       first;
      logic       last;
      dest_type   dest;
      logic [1:0] sh;
   } prod_tag_type;

   typedef enum logic [3:0] {
      B_IDLE, B_READJ, B_GRABJ, B_READI, B_SUMS, B_MAC, B_DRAIN,
      B_PREP, B_CHECK, B_DIV, B_EMIT
   } back_state_type;

   // D = n*Sxx - Sx^2, N = n*Sxy - Sx*Sy, V = n*Syy - Sy^2, DEN = n*D, NUM = V*D - N^2
   // a result is written after its last partial, so DEN sits between V and its use
   function automatic mac_op_type mac_op(input logic [PIDX_W-1:0] idx);
      mac_op_type op;
      op = '{a: OPD_N, b: OPD_N, sub: 1'b0, first: 1'b1, last: 1'b1, dest: DST_DEN};
      unique case (idx)
         PIDX_W'(0): op = '{OPD_N,  OPD_SXX, 1'b0, 1'b1, 1'b0, DST_D};
         PIDX_W'(1): op = '{OPD_SX, OPD_SX,  1'b1, 1'b0, 1'b1, DST_D};
         PIDX_W'(2): op = '{OPD_N,  OPD_SXY, 1'b0, 1'b1, 1'b0, DST_N};
         PIDX_W'(3): op = '{OPD_SX, OPD_SY,  1'b1, 1'b0, 1'b1, DST_N};
         PIDX_W'(4): op = '{OPD_N,  OPD_SYY, 1'b0, 1'b1, 1'b0, DST_V};
         PIDX_W'(5): op = '{OPD_SY, OPD_SY,  1'b1, 1'b0, 1'b1, DST_V};
         PIDX_W'(6): op = '{OPD_N,  OPD_D,   1'b0, 1'b1, 1'b1, DST_DEN};
         PIDX_W'(7): op = '{OPD_V,  OPD_D,   1'b0, 1'b1, 1'b0, DST_NUM};
         PIDX_W'(8): op = '{OPD_NN, OPD_NN,  1'b1, 1'b0, 1'b1, DST_NUM};
         default:    op = '{OPD_N,  OPD_N,   1'b0, 1'b1, 1'b1, DST_DEN};
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/segment_line_fit_error.sv =====
// Least-squares line-fit error for every segment ending at each new point.
// A point with index j gives j results. Each fit result runs its products through the shared
// 25x25 multiplier and then, unless it is vertical, negative or saturated, through the
// one-bit-per-cycle divider; order and full rejects give a single result each.
// Reset is synchronous: it clears the point count and all control, not the prefix memory.
`default_nettype none

module segment_line_fit_error (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [slfe_pkg::IN_DATA_W-1:0]      req_tdata,  // [15:0] coord_x, [31:16] coord_y
   input  logic [slfe_pkg::IN_USER_W-1:0]      req_tuser,  // [0] first
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [slfe_pkg::OUT_DATA_W-1:0]     rsp_tdata,  // [5:0] seg_start, [11:6] seg_end,
                                                           // [59:12] fit_error
   output logic [slfe_pkg::OUT_USER_W-1:0]     rsp_tuser,  // [1:0] status
   output logic                                rsp_tlast   // last_of_run
);
   import slfe_pkg::*;

   logic             push;
   job_type          push_job;
   logic             pop;
   job_type          head_job;
   queue_stat_type   qstat;
   logic             back_idle;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   prefix_type       wr_data;
   logic [IDX_W-1:0] rd_addr;
   prefix_type       rd_data;

   slfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_job   (push_job),
      .qstat      (qstat),
      .back_idle  (back_idle),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   slfe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   slfe_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_POINTS)
   ) u_prefix_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   slfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .qstat      (qstat),
      .pop        (pop),
      .back_idle  (back_idle),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/slfe_ram.sv =====
`default_nettype none

module slfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/slfe_front.sv =====
`default_nettype none

module slfe_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [slfe_pkg::IN_DATA_W-1:0]      req_tdata,  // [15:0] coord_x, [31:16] coord_y
   input  logic [slfe_pkg::IN_USER_W-1:0]      req_tuser,  // [0] first
   output logic                                push,
   output slfe_pkg::job_type                   push_job,
   input  slfe_pkg::queue_stat_type            qstat,
   input  logic                                back_idle,
   output logic                                wr_en,
   output logic [slfe_pkg::IDX_W-1:0]          wr_addr,
   output slfe_pkg::prefix_type                wr_data
);
   import slfe_pkg::*;

   logic                          hold_valid_ff;
   logic                          hold_first_ff;
   logic signed [COORD_BITS-1:0]  hold_x_ff;
   logic signed [COORD_BITS-1:0]  hold_y_ff;
   logic [CNT_W-1:0]              count_ff;
   logic signed [COORD_BITS-1:0]  prev_x_ff;
   logic signed [COORD_BITS-1:0]  prev_y_ff;
   prefix_type                    run_ff;

   logic                          go;
   logic [CNT_W-1:0]              cnt_eff;
   logic                          is_full;
   logic                          is_order;
   logic signed [2*COORD_BITS-1:0] prod_xy;
   logic signed [2*COORD_BITS-1:0] prod_xx;
   logic signed [2*COORD_BITS-1:0] prod_yy;
   prefix_type                    base;
   prefix_type                    next_prefix;

   // a new set waits until every job of the old set has left the back end
   assign go = hold_valid_ff && !qstat.full &&
               (!hold_first_ff || (qstat.empty && back_idle));
   assign req_tready = !hold_valid_ff || go;

   assign cnt_eff  = hold_first_ff ? '0 : count_ff;
   assign is_full  = (cnt_eff == CNT_W'(MAX_POINTS));
   assign is_order = (cnt_eff != '0) &&
                     ((hold_x_ff < prev_x_ff) ||
                      ((hold_x_ff == prev_x_ff) && (hold_y_ff < prev_y_ff)));

   assign prod_xy = hold_x_ff * hold_y_ff;
   assign prod_xx = hold_x_ff * hold_x_ff;
   assign prod_yy = hold_y_ff * hold_y_ff;

   always_comb begin
      base = (cnt_eff == '0) ? '0 : run_ff;
      next_prefix.sx  = $signed(base.sx)  + PS_W'(hold_x_ff);
      next_prefix.sy  = $signed(base.sy)  + PS_W'(hold_y_ff);
      next_prefix.sxy = $signed(base.sxy) + PXY_W'(prod_xy);
      next_prefix.sxx = base.sxx + PSQ_W'($unsigned(prod_xx));
      next_prefix.syy = base.syy + PSQ_W'($unsigned(prod_yy));
   end

   assign wr_en   = go && !is_full && !is_order;
   assign wr_addr = IDX_W'(cnt_eff);
   assign wr_data = next_prefix;

   // the first point of a set is stored without any result
   assign push = go && (is_full || is_order || (cnt_eff != '0));

   always_comb begin
      push_job.j = IDX_W'(cnt_eff);
      if (is_full) begin
         push_job.kind = JOB_FULL;
         push_job.j    = '0;
      end else if (is_order) begin
         push_job.kind = JOB_ORDER;
         push_job.j    = '0;
      end else begin
         push_job.kind = JOB_FIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         count_ff      <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            hold_valid_ff <= 1'b1;
         end else if (go) begin
            hold_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            count_ff  <= cnt_eff + CNT_W'(1);
            prev_x_ff <= hold_x_ff;
            prev_y_ff <= hold_y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         hold_first_ff <= req_tuser[0];
         hold_x_ff     <= req_tdata[COORD_BITS-1:0];
         hold_y_ff     <= req_tdata[FIELD_W+COORD_BITS-1:FIELD_W];
      end
      if (wr_en) begin
         run_ff <= next_prefix;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/slfe_queue.sv =====
`default_nettype none
`include "assert_macros.svh"

module slfe_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  slfe_pkg::job_type         push_job,
   input  logic                      pop,
   output slfe_pkg::job_type         head_job,
   output slfe_pkg::queue_stat_type  qstat
);
   import slfe_pkg::*;

   job_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W:0]    count_ff;

   assign head_job    = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QPTR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QPTR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ASSERT_NEVER(a_queue_overflow, push && qstat.full, "job pushed into a full queue")
   `ASSERT_NEVER(a_queue_underflow, pop && qstat.empty, "job popped from an empty queue")

endmodule

`default_nettype wire

// ===== hw/rtl/slfe_back.sv =====
`default_nettype none
`include "assert_macros.svh"

module slfe_back (
   input  logic                                clock,
   input  logic                                reset,
   input  slfe_pkg::job_type                   head_job,
   input  slfe_pkg::queue_stat_type            qstat,
   output logic                                pop,
   output logic                                back_idle,
   output logic [slfe_pkg::IDX_W-1:0]          rd_addr,
   input  slfe_pkg::prefix_type                rd_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [slfe_pkg::OUT_DATA_W-1:0]     rsp_tdata,  // [5:0] seg_start, [11:6] seg_end,
                                                           // [59:12] fit_error
   output logic [slfe_pkg::OUT_USER_W-1:0]     rsp_tuser,  // [1:0] status
   output logic                                rsp_tlast   // last_of_run
);
   import slfe_pkg::*;

   back_state_type            state_ff;
   back_state_type            state_in;
   job_kind_type              kind_ff;
   logic [IDX_W-1:0]          j_ff;
   logic [IDX_W-1:0]          i_ff;
   prefix_type                pj_ff;

   logic signed [PS_W-1:0]    sx_ff;
   logic signed [PS_W-1:0]    sy_ff;
   logic signed [PXY_W-1:0]   sxy_ff;
   logic [PSQ_W-1:0]          sxx_ff;
   logic [PSQ_W-1:0]          syy_ff;
   logic [CNT_W-1:0]          n_ff;

   logic [STEP_W-1:0]         step_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   prod_tag_type              ptag_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [OP_W-1:0]    d_ff;
   logic signed [OP_W-1:0]    nn_ff;
   logic signed [OP_W-1:0]    v_ff;
   logic signed [ACC_W-1:0]   num_ff;
   logic signed [ACC_W-1:0]   den_ff;

   logic [REM_W-1:0]          rem_ff;
   logic [REM_W-1:0]          d2_ff;
   logic [ERR_W-1:0]          lo_ff;
   logic [ERR_W-1:0]          q_ff;
   logic [QCNT_W-1:0]         qcnt_ff;
   logic [ERR_W-1:0]          res_err_ff;
   status_type                res_status_ff;

   logic                      rsp_valid_ff;
   logic [OUT_DATA_W-1:0]     rsp_data_ff;
   logic [OUT_USER_W-1:0]     rsp_user_ff;
   logic                      rsp_last_ff;

   prefix_type                pi_sel;
   mac_op_type                op;
   logic signed [OP_W-1:0]    opa;
   logic signed [OP_W-1:0]    opb;
   logic signed [HALF_W:0]    a_part;
   logic signed [HALF_W:0]    b_part;
   logic signed [ACC_W-1:0]   term_ext;
   logic signed [ACC_W-1:0]   term;
   logic signed [ACC_W-1:0]   acc_base;
   logic signed [ACC_W-1:0]   acc_new;
   logic [DIV_W-1:0]          nump;
   logic [REM_W-1:0]          trial;
   logic                      trial_ge;
   logic                      out_free;
   logic                      run_done;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign run_done = (kind_ff != JOB_FIT) ||
                     ((CNT_W'(i_ff) + CNT_W'(1)) == CNT_W'(j_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (!qstat.empty) state_in = (head_job.kind == JOB_FIT) ? B_READJ : B_EMIT;
         B_READJ: state_in = B_GRABJ;
         B_GRABJ: state_in = B_READI;
         B_READI: state_in = B_SUMS;
         B_SUMS:  state_in = B_MAC;
         B_MAC:   if (step_ff == STEP_W'(STEP_LAST)) state_in = B_DRAIN;
         B_DRAIN: if (!ptag_ff.valid) state_in = B_PREP;
         B_PREP:  state_in = ((d_ff == '0) || num_ff[ACC_W-1]) ? B_EMIT : B_CHECK;
         B_CHECK: state_in = (rem_ff >= d2_ff) ? B_EMIT : B_DIV;
         B_DIV:   if (qcnt_ff == QCNT_W'(ERR_W - 1)) state_in = B_EMIT;
         B_EMIT:  if (out_free) state_in = run_done ? B_IDLE : B_READI;
         default: state_in = B_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop       = 1'b0;
      back_idle = 1'b0;
      rd_addr   = j_ff;
      unique case (state_ff)
         B_IDLE: begin
            pop       = !qstat.empty;
            back_idle = 1'b1;
         end
         B_READI: rd_addr = IDX_W'(i_ff - IDX_W'(1));
         default: rd_addr = j_ff;
      endcase
   end

   // partial-product operands
   always_comb begin
      op = mac_op(step_ff[STEP_W-1:2]);
      case (op.a)
         OPD_N:   opa = OP_W'(n_ff);
         OPD_SX:  opa = OP_W'(sx_ff);
         OPD_SY:  opa = OP_W'(sy_ff);
         OPD_SXY: opa = OP_W'(sxy_ff);
         OPD_SXX: opa = OP_W'(sxx_ff);
         OPD_SYY: opa = OP_W'(syy_ff);
         OPD_D:   opa = d_ff;
         OPD_NN:  opa = nn_ff;
         OPD_V:   opa = v_ff;
         default: opa = '0;
      endcase
      case (op.b)
         OPD_N:   opb = OP_W'(n_ff);
         OPD_SX:  opb = OP_W'(sx_ff);
         OPD_SY:  opb = OP_W'(sy_ff);
         OPD_SXY: opb = OP_W'(sxy_ff);
         OPD_SXX: opb = OP_W'(sxx_ff);
         OPD_SYY: opb = OP_W'(syy_ff);
         OPD_D:   opb = d_ff;
         OPD_NN:  opb = nn_ff;
         OPD_V:   opb = v_ff;
         default: opb = '0;
      endcase
      // low halves are unsigned, high halves carry the sign
      a_part = step_ff[1] ? $signed({opa[OP_W-1], opa[OP_W-1:HALF_W]})
                          : $signed({1'b0, opa[HALF_W-1:0]});
      b_part = step_ff[0] ? $signed({opb[OP_W-1], opb[OP_W-1:HALF_W]})
                          : $signed({1'b0, opb[HALF_W-1:0]});
   end

   always_comb begin
      term_ext = ACC_W'(prod_ff);
      case (ptag_ff.sh)
         2'd0:    term = term_ext;
         2'd1:    term = term_ext <<< HALF_W;
         default: term = term_ext <<< (2 * HALF_W);
      endcase
      acc_base = ptag_ff.first ? '0 : acc_ff;
      acc_new  = ptag_ff.sub ? (acc_base - term) : (acc_base + term);
   end

   always_comb begin
      pi_sel   = (i_ff == '0) ? '0 : rd_data;
      nump     = (DIV_W'($unsigned(num_ff)) << (FRAC_BITS + 1)) +
                 DIV_W'($unsigned(den_ff));
      trial    = {rem_ff[REM_W-2:0], lo_ff[ERR_W-1]};
      trial_ge = (trial >= d2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (state_ff == B_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptag_ff.valid <= 1'b0;
      end else begin
         ptag_ff.valid <= (state_ff == B_MAC);
      end

      // accumulate stage, working on each product in the cycle after the multiplier forms it
      if (ptag_ff.valid) begin
         acc_ff <= acc_new;
         if (ptag_ff.last) begin
            case (ptag_ff.dest)
               DST_D:   d_ff   <= OP_W'(acc_new);
               DST_N:   nn_ff  <= OP_W'(acc_new);
               DST_V:   v_ff   <= OP_W'(acc_new);
               DST_NUM: num_ff <= acc_new;
               default: den_ff <= acc_new;
            endcase
         end
      end

      unique case (state_ff)
         B_IDLE: begin
            kind_ff    <= head_job.kind;
            j_ff       <= head_job.j;
            i_ff       <= '0;
            res_err_ff <= '0;
            res_status_ff <= (head_job.kind == JOB_FULL) ? ST_FULL : ST_ORDER;
         end
         B_GRABJ: pj_ff <= rd_data;
         B_SUMS: begin
            sx_ff   <= $signed(pj_ff.sx)  - $signed(pi_sel.sx);
            sy_ff   <= $signed(pj_ff.sy)  - $signed(pi_sel.sy);
            sxy_ff  <= $signed(pj_ff.sxy) - $signed(pi_sel.sxy);
            sxx_ff  <= pj_ff.sxx - pi_sel.sxx;
            syy_ff  <= pj_ff.syy - pi_sel.syy;
            n_ff    <= CNT_W'(j_ff) - CNT_W'(i_ff) + CNT_W'(1);
            step_ff <= '0;
         end
         B_MAC: begin
            prod_ff       <= a_part * b_part;
            ptag_ff.sub   <= op.sub;
            ptag_ff.first <= op.first && (step_ff[1:0] == 2'd0);
            ptag_ff.last  <= op.last && (step_ff[1:0] == 2'd3);
            ptag_ff.dest  <= op.dest;
            ptag_ff.sh    <= 2'(step_ff[1]) + 2'(step_ff[0]);
            step_ff       <= step_ff + STEP_W'(1);
         end
         B_PREP: begin
            res_err_ff    <= '0;
            res_status_ff <= (d_ff == '0) ? ST_VERTICAL : ST_OK;
            rem_ff        <= REM_W'(nump >> ERR_W);
            lo_ff         <= nump[ERR_W-1:0];
            d2_ff         <= REM_W'($unsigned(den_ff)) << 1;
            q_ff          <= '0;
            qcnt_ff       <= '0;
         end
         B_CHECK: begin
            // quotient would need more than the output width: saturate
            if (rem_ff >= d2_ff) begin
               res_err_ff <= '1;
            end
         end
         B_DIV: begin
            rem_ff  <= trial_ge ? (trial - d2_ff) : trial;
            lo_ff   <= lo_ff << 1;
            q_ff    <= {q_ff[ERR_W-2:0], trial_ge};
            qcnt_ff <= qcnt_ff + QCNT_W'(1);
            if (qcnt_ff == QCNT_W'(ERR_W - 1)) begin
               res_err_ff <= {q_ff[ERR_W-2:0], trial_ge};
            end
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_data_ff <= {{OUT_PAD_W{1'b0}}, res_err_ff,
                               (kind_ff == JOB_FIT) ? SEG_W'(j_ff) : SEG_W'(0),
                               (kind_ff == JOB_FIT) ? SEG_W'(i_ff) : SEG_W'(0)};
               rsp_user_ff <= res_status_ff;
               rsp_last_ff <= run_done;
               i_ff        <= i_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_CLK(a_seg_in_range, (state_ff == B_EMIT && kind_ff == JOB_FIT) |-> (i_ff < j_ff),
      "segment start not below segment end")
   `ASSERT_CLK(a_div_steps, (state_ff == B_DIV) |-> (qcnt_ff < QCNT_W'(ERR_W)),
      "divider ran past the quotient width")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import slfe_pkg::*;

   localparam int IDLE_LIMIT = 10000;
   localparam int HOLD_OFF   = 3000;
   localparam int ITEM_GOAL  = 470;

   typedef struct {
      logic [SEG_W-1:0] seg_start;
      logic [SEG_W-1:0] seg_end;
      logic [ERR_W-1:0] fit_error;
      status_type       status;
      logic             last;
   } fit_result_type;

   typedef struct {
      bit               first;
      logic [15:0]      x;
      logic [15:0]      y;
      bit               typed;
      status_type       typed_status;
   } point_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata = '0;   // [15:0] coord_x, [31:16] coord_y
   logic [IN_USER_W-1:0]  req_tuser = '0;   // [0] first
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;        // [5:0] seg_start, [11:6] seg_end, [59:12] fit_error
   logic [OUT_USER_W-1:0] rsp_tuser;        // [1:0] status
   logic                  rsp_tlast;

   fit_result_type fit_q[$];
   fit_result_type point_results[$];

   // predictor state
   int      stored_points = 0;
   longint  last_x = 0, last_y = 0;
   longint  sum_x[MAX_POINTS], sum_y[MAX_POINTS], sum_xy[MAX_POINTS];
   longint  sum_xx[MAX_POINTS], sum_yy[MAX_POINTS];

   int  mismatches = 0;
   int  points_sent = 0;
   int  results_seen = 0;
   int  status_seen[4] = '{0, 0, 0, 0};
   int  burst_left = 0;
   int  idle_cycles = 0;
   bit  stimulus_done = 1'b0;

   segment_line_fit_error u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic status_type fit_segment(input int i, input int j,
                                               output logic [ERR_W-1:0] err);
      logic signed [255:0] n, sx, sy, sxy, sxx, syy, d, nn, v, num, den, q;
      n   = j - i + 1;
      sx  = (i == 0) ? sum_x[j]  : sum_x[j]  - sum_x[i-1];
      sy  = (i == 0) ? sum_y[j]  : sum_y[j]  - sum_y[i-1];
      sxy = (i == 0) ? sum_xy[j] : sum_xy[j] - sum_xy[i-1];
      sxx = (i == 0) ? sum_xx[j] : sum_xx[j] - sum_xx[i-1];
      syy = (i == 0) ? sum_yy[j] : sum_yy[j] - sum_yy[i-1];
      d = n * sxx - sx * sx;
      err = '0;
      if (d == 0) return ST_VERTICAL;
      nn  = n * sxy - sx * sy;
      v   = n * syy - sy * sy;
      num = v * d - nn * nn;
      if (num < 0) return ST_OK;
      den = n * d;
      // round half up with FRAC_BITS fraction bits
      q = (num * (256'sd1 <<< (FRAC_BITS + 1)) + den) / (2 * den);
      if (q > 256'sh0FFFF_FFFF_FFFF) err = '1;
      else err = q[ERR_W-1:0];
      return ST_OK;
   endfunction

   // fills point_results with what one accepted point yields
   function automatic void predict_point(input bit first, input logic [15:0] xr,
                                         input logic [15:0] yr);
      longint     x, y;
      int         j;
      fit_result_type r;
      x = longint'($signed(xr));
      y = longint'($signed(yr));
      point_results.delete();
      if (first) stored_points = 0;
      if (stored_points >= MAX_POINTS || (stored_points > 0 &&
          (x < last_x || (x == last_x && y < last_y)))) begin
         r = '{seg_start: '0, seg_end: '0, fit_error: '0, last: 1'b1,
               status: (stored_points >= MAX_POINTS) ? ST_FULL : ST_ORDER};
         point_results.push_back(r);
         return;
      end
      j = stored_points;
      sum_x[j]  = x;
      sum_y[j]  = y;
      sum_xy[j] = x * y;
      sum_xx[j] = x * x;
      sum_yy[j] = y * y;
      if (j > 0) begin
         sum_x[j]  += sum_x[j-1];
         sum_y[j]  += sum_y[j-1];
         sum_xy[j] += sum_xy[j-1];
         sum_xx[j] += sum_xx[j-1];
         sum_yy[j] += sum_yy[j-1];
      end
      last_x = x;
      last_y = y;
      stored_points = j + 1;
      for (int i = 0; i < j; i++) begin
         r.status    = fit_segment(i, j, r.fit_error);
         r.seg_start = SEG_W'(i);
         r.seg_end   = SEG_W'(j);
         r.last      = (i + 1 == j);
         point_results.push_back(r);
      end
   endfunction

   task automatic offer_point(input point_row_type row);
      int gap;
      fit_result_type r;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= row.first;
      req_tdata  <= {row.y, row.x};
      do @(posedge clock); while (!req_tready);
      predict_point(row.first, row.x, row.y);
      if (row.typed) begin
         r = '{seg_start: '0, seg_end: '0, fit_error: '0, status: row.typed_status,
               last: 1'b1};
         fit_q.push_back(r);
      end else begin
         foreach (point_results[k]) fit_q.push_back(point_results[k]);
      end
      points_sent++;
      burst_left--;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (fit_q.size() == 0);
      repeat (20) @(negedge clock);
   endtask

   // sorted set of points, some replaced by random points for noise
   task automatic send_set(input int count, input bit fresh, input int spread,
                           input int noise_pct);
      bit [31:0] keys[$];
      point_row_type row;
      logic [15:0] base_x, base_y;
      base_x = $urandom;
      base_y = $urandom;
      for (int k = 0; k < count; k++) begin
         if (spread == 0)
            keys.push_back($urandom);
         else
            keys.push_back({16'(base_x + $urandom_range(0, spread)) ^ 16'h8000,
                            16'(base_y + $urandom_range(0, spread)) ^ 16'h8000});
      end
      keys.sort();
      foreach (keys[k]) begin
         row = '{first: fresh && (k == 0), x: keys[k][31:16] ^ 16'h8000,
                 y: keys[k][15:0] ^ 16'h8000, typed: 1'b0, typed_status: ST_OK};
         if (k > 0 && $urandom_range(0, 99) < noise_pct) begin
            row.x = $urandom;
            row.y = $urandom;
         end
         offer_point(row);
      end
   endtask

   // receiver: changing stall pattern plus one long hold-off
   initial begin
      int  mode;
      bit  held;
      held = 1'b0;
      mode = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!held && results_seen >= 100) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
         end
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ~rsp_tready;
            default: rsp_tready <= ($urandom_range(0, 9) < 6);
         endcase
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      fit_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         status_seen[rsp_tuser]++;
         if (fit_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected item seg %0d..%0d status %0d", $realtime,
                        rsp_tdata[5:0], rsp_tdata[11:6], rsp_tuser);
         end else begin
            e = fit_q.pop_front();
            if (rsp_tdata[5:0] !== e.seg_start || rsp_tdata[11:6] !== e.seg_end ||
                rsp_tdata[59:12] !== e.fit_error || rsp_tuser !== e.status ||
                rsp_tlast !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: expected seg %0d..%0d err %h st %0d last %0b,",
                           $realtime, e.seg_start, e.seg_end, e.fit_error, e.status,
                           e.last, " got %0d..%0d err %h st %0d last %0b",
                           rsp_tdata[5:0], rsp_tdata[11:6], rsp_tdata[59:12],
                           rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (stimulus_done && fit_q.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d cycles without progress", IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      point_row_type directed[] = '{
         '{1, 16'h8000, 16'h8000, 0, ST_OK},      // first point, most negative
         '{0, 16'h8000, 16'h7FFF, 0, ST_OK},      // same x: vertical
         '{0, 16'h7FFF, 16'h8000, 0, ST_OK},
         '{0, 16'h7FFF, 16'h7FFF, 0, ST_OK},
         '{0, 16'h0000, 16'h0000, 1, ST_ORDER},   // x goes back
         '{0, 16'h7FFF, 16'h7FFF, 0, ST_OK},      // equal to previous
         '{1, 16'h0005, 16'h0005, 0, ST_OK},
         '{0, 16'h0005, 16'h0004, 1, ST_ORDER},   // same x, y goes back
         '{0, 16'h0005, 16'h0005, 0, ST_OK},
         '{0, 16'h0006, 16'h0064, 0, ST_OK},
         '{0, 16'h0007, 16'hFF9C, 0, ST_OK},
         '{1, 16'h0000, 16'h0000, 0, ST_OK},      // collinear run
         '{0, 16'h0001, 16'h0001, 0, ST_OK},
         '{0, 16'h0002, 16'h0002, 0, ST_OK},
         '{0, 16'h0003, 16'h0003, 0, ST_OK},
         '{1, 16'hFFFF, 16'h0000, 0, ST_OK},
         '{0, 16'h0000, 16'hFFFF, 0, ST_OK}
      };
      point_row_type row;
      int sets;
      bit full_done;
      sets = 0;
      full_done = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[k]) offer_point(directed[k]);
      drain_results();

      while (points_sent < ITEM_GOAL) begin
         sets++;
         if (!full_done && points_sent > 200) begin
            // fill the store, then two more points that must bounce
            drain_results();
            send_set(MAX_POINTS, 1'b1, 0, 0);
            row = '{first: 0, x: 16'h7FFF, y: 16'h7FFF, typed: 1, typed_status: ST_FULL};
            offer_point(row);
            row.x = 16'h8000;
            offer_point(row);
            full_done = 1'b1;
            drain_results();
         end else if ($urandom_range(0, 19) == 0 && stored_points < 30) begin
            send_set($urandom_range(1, 4), 1'b0, $urandom_range(0, 40), 20);
         end else if ($urandom_range(0, 11) == 0) begin
            send_set($urandom_range(11, 20), 1'b1, 0, 5);
         end else begin
            send_set($urandom_range(2, 10), 1'b1,
                     ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 12), 8);
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      stimulus_done = 1'b1;
      wait (fit_q.size() == 0);
      repeat (200) @(posedge clock);
      $display("Sent %0d points in %0d sets; checked %0d results", points_sent, sets,
               results_seen);
      $display("Status mix: ok %0d, vertical %0d, order %0d, full %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (mismatches == 0 && fit_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
